[src/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and the CRC-16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int MAGIC_W = 48;
  localparam int COUNT_W = 16;

  localparam logic [MAGIC_W-1:0] MAGIC_RESET   = 48'h585858434944;
  localparam logic [15:0]        CRC_INIT      = 16'hFFFF;
  localparam logic [15:0]        CRC_POLY      = 16'hA001;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [COUNT_W-1:0] MAX_FRAME_LEN = 16'd8192;
  localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 16'd8;
  localparam logic [COUNT_W-1:0] HDR_LEN       = 16'd6;
  localparam logic [COUNT_W-1:0] CMD_POS       = 16'd6;
  localparam logic [COUNT_W-1:0] KIND_POS      = 16'd7;
  localparam logic [COUNT_W-1:0] ADDR_FIRST    = 16'd28;
  localparam logic [COUNT_W-1:0] ADDR_LAST     = 16'd31;
  localparam logic [COUNT_W-1:0] ADDR_MIN_LEN  = 16'd32;
  localparam logic [COUNT_W-1:0] CRC_DELAY     = 16'd2;

  localparam logic [7:0] FWD_KIND      = 8'd1;
  localparam logic [7:0] FWD_CMD_LONG  = 8'd6;
  localparam logic [7:0] FWD_CMD_SHORT = 8'd60;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_LONG  = 2'd1;
  localparam logic [1:0] ACT_SHORT = 2'd2;

  typedef struct packed {
    logic        frame_ok;
    logic        header_ok;
    logic        length_ok;
    logic        crc_ok;
    logic [7:0]  cmd_code;
    logic [7:0]  kind_code;
    logic [1:0]  forward_action;
    logic [31:0] dest_addr;
  } result_t;

  // One byte of reflected CRC-16/MODBUS, fully unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/cfc_frame_core.sv]
// ----------------------------------------------------------------------------
// cfc_frame_core
// Per-frame state: byte count, delayed CRC, trailing bytes and held fields.
// Produces the frame verdict combinationally on the final word.
// ----------------------------------------------------------------------------
module cfc_frame_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic [cfc_pkg::MAGIC_W-1:0]  header_magic,
  output cfc_pkg::result_t             res
);
  import cfc_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        crc_reg, crc_reg_next;
  logic [31:0]        tail_bytes, tail_bytes_next;
  logic               header_match, header_match_next;
  logic [7:0]         cmd_hold, cmd_hold_next;
  logic [7:0]         kind_hold, kind_hold_next;
  logic [31:0]        addr_hold, addr_hold_next;
  logic [7:0]         exp_byte;
  logic               len_ok, crc_ok, hdr_ok, ok;

  always_comb begin
    case (byte_count[2:0])
      3'd0:    exp_byte = header_magic[47:40];
      3'd1:    exp_byte = header_magic[39:32];
      3'd2:    exp_byte = header_magic[31:24];
      3'd3:    exp_byte = header_magic[23:16];
      3'd4:    exp_byte = header_magic[15:8];
      3'd5:    exp_byte = header_magic[7:0];
      default: exp_byte = 8'h00;
    endcase
  end

  always_comb begin
    header_match_next = header_match;
    if (byte_count < HDR_LEN && exp_byte != data_byte) begin
      header_match_next = 1'b0;
    end
    cmd_hold_next  = (byte_count == CMD_POS)  ? data_byte : cmd_hold;
    kind_hold_next = (byte_count == KIND_POS) ? data_byte : kind_hold;
    addr_hold_next = addr_hold;
    if (byte_count >= ADDR_FIRST && byte_count <= ADDR_LAST) begin
      addr_hold_next = {addr_hold[23:0], data_byte};
    end
    // The CRC runs two bytes behind the stream so it never sees the trailer.
    crc_reg_next = (byte_count >= CRC_DELAY) ? crc16_byte(crc_reg, tail_bytes[15:8])
                                             : crc_reg;
    tail_bytes_next = {tail_bytes[23:0], data_byte};
    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 16'd1 : byte_count;
  end

  always_comb begin
    hdr_ok = (byte_count_next >= HDR_LEN) && header_match_next;
    len_ok = (byte_count_next >= MIN_FRAME_LEN) &&
             (tail_bytes_next[31:16] == byte_count_next);
    crc_ok = (byte_count_next >= MIN_FRAME_LEN) &&
             (tail_bytes_next[15:8] == crc_reg_next[7:0]) &&
             (tail_bytes_next[7:0] == crc_reg_next[15:8]);
    ok = hdr_ok && len_ok && crc_ok && (byte_count_next <= MAX_FRAME_LEN);

    res.frame_ok       = ok;
    res.header_ok      = hdr_ok;
    res.length_ok      = len_ok;
    res.crc_ok         = crc_ok;
    res.cmd_code       = cmd_hold_next;
    res.kind_code      = kind_hold_next;
    res.forward_action = ACT_NONE;
    if (ok && kind_hold_next == FWD_KIND) begin
      if (cmd_hold_next == FWD_CMD_LONG) begin
        res.forward_action = ACT_LONG;
      end else if (cmd_hold_next == FWD_CMD_SHORT) begin
        res.forward_action = ACT_SHORT;
      end
    end
    res.dest_addr = (byte_count_next >= ADDR_MIN_LEN) ? addr_hold_next : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      byte_count   <= '0;
      crc_reg      <= CRC_INIT;
      tail_bytes   <= '0;
      header_match <= 1'b1;
      cmd_hold     <= '0;
      kind_hold    <= '0;
      addr_hold    <= '0;
    end else if (fire) begin
      byte_count   <= byte_count_next;
      crc_reg      <= crc_reg_next;
      tail_bytes   <= tail_bytes_next;
      header_match <= header_match_next;
      cmd_hold     <= cmd_hold_next;
      kind_hold    <= kind_hold_next;
      addr_hold    <= addr_hold_next;
    end
  end

endmodule

[src/cfc_result_reg.sv]
// ----------------------------------------------------------------------------
// cfc_result_reg
// Result register holding one verdict word until the receiver takes it.
// ----------------------------------------------------------------------------
module cfc_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cfc_pkg::result_t  res_in,
  input  logic              out_stall,
  output logic              out_valid,
  output cfc_pkg::result_t  res_out
);
  import cfc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[src/crc16_frame_checker_unit.sv]
// ----------------------------------------------------------------------------
// crc16_frame_checker_unit
// Byte-stream datagram checker: header magic, length field and CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// The verdict word is registered twice after the final byte is accepted: in the
// input register, then in the result register, where a stalled verdict can hold it.
// Throughput: one byte per cycle; the CRC byte update is unrolled into a single
// logic stage. Only a final byte can wait, and only while a stalled verdict holds.
// Reset (synchronous, active high) clears all frame state, empties both
// registers and restores the header magic to its default value.
module crc16_frame_checker_unit (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port for the header magic.
  input  logic                         cfg_wr_en,
  input  logic [cfc_pkg::MAGIC_W-1:0]  cfg_wr_data,
  // Input word channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  // Result word channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         frame_ok,
  output logic                         header_ok,
  output logic                         length_ok,
  output logic                         crc_ok,
  output logic [7:0]                   cmd_code,
  output logic [7:0]                   kind_code,
  output logic [1:0]                   forward_action,
  output logic [31:0]                  dest_addr
);
  import cfc_pkg::*;

  logic [MAGIC_W-1:0] header_magic;

  // Input register: holds one accepted word until the frame logic consumes it.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  logic    out_free;
  logic    s1_fire;
  result_t core_res;
  result_t out_res;

  // The result register is free when empty or when its word leaves now.
  assign out_free = !out_valid || !out_stall;

  // A non-final byte only updates frame state, so it never waits on the
  // output side. A final byte needs the result register.
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_magic <= MAGIC_RESET;
    end else if (cfg_wr_en) begin
      header_magic <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Frame state and verdict logic.
  cfc_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (s1_fire),
    .data_byte    (s1_byte),
    .last_byte    (s1_last),
    .header_magic (header_magic),
    .res          (core_res)
  );

  // Result register; loaded only by a final byte.
  cfc_result_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_fire && s1_last),
    .res_in    (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign frame_ok       = out_res.frame_ok;
  assign header_ok      = out_res.header_ok;
  assign length_ok      = out_res.length_ok;
  assign crc_ok         = out_res.crc_ok;
  assign cmd_code       = out_res.cmd_code;
  assign kind_code      = out_res.kind_code;
  assign forward_action = out_res.forward_action;
  assign dest_addr      = out_res.dest_addr;

endmodule
